>>> src/buzzer_pattern_sequencer_macros.svh
// Assertion macros for the buzzer pattern sequencer checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BUZZER_PATTERN_SEQUENCER_MACROS_SVH
`define BUZZER_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, ignored while rst is high.
`define BPS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbl failed");

// Next-cycle implication, ignored while rst is high.
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbl failed");

// Next-cycle implication that is also checked across reset.
`define BPS_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

>>> src/bps_pkg.sv
// Package for the buzzer pattern sequencer: request codes, request and
// result structs, and the pattern step ROM. No dependencies.
`timescale 1ns / 1ps

package bps_pkg;

  localparam logic [1:0] REQ_PLAY = 2'd0;
  localparam logic [1:0] REQ_STOP = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam int unsigned ROM_PATTERNS = 8;
  localparam int unsigned ROM_DEPTH    = 32;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  pattern_id;
    logic [63:0] now_ms;
  } req_t;

  typedef struct packed {
    logic buzzer_on;
    logic playing;
  } res_t;

  // step tables, padded to a power of two
  localparam logic STEP_LEVEL [ROM_DEPTH] = '{
    0: 1'b1, 2: 1'b1, 4: 1'b1, 6: 1'b1, 8: 1'b1, 10: 1'b1,
    12: 1'b1, 14: 1'b1, 16: 1'b1, 18: 1'b1, 20: 1'b1, default: 1'b0
  };

  localparam logic [7:0] STEP_DUR [ROM_DEPTH] = '{
    0: 8'd100, 2: 8'd120, 3: 8'd120, 4: 8'd120, 6: 8'd90, 7: 8'd60,
    8: 8'd160, 10: 8'd180, 12: 8'd90, 13: 8'd90, 14: 8'd90, 16: 8'd220,
    17: 8'd80, 18: 8'd220, 20: 8'd250, default: 8'd0
  };

  localparam logic [4:0] PAT_BASE [ROM_PATTERNS] = '{
    5'd0, 5'd2, 5'd6, 5'd10, 5'd12, 5'd16, 5'd20, 5'd0
  };

  localparam logic [2:0] PAT_LEN [ROM_PATTERNS] = '{
    3'd2, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd2, 3'd0
  };

endpackage

>>> src/bps_rom.sv
// Pattern ROM lookup: step level and duration at a position, and the
// pattern length clamped to MAX_STEPS. Depends on bps_pkg.
`timescale 1ns / 1ps

module bps_rom import bps_pkg::*; #(
  parameter int MAX_STEPS = 4
) (
  input  logic [2:0] pattern,
  input  logic [2:0] position,
  output logic       level,
  output logic [7:0] dur,
  output logic [2:0] len
);

  localparam logic [4:0] MaxSteps = 5'(MAX_STEPS);

  logic [4:0] idx;
  logic [2:0] len_raw;

  assign idx     = PAT_BASE[pattern] + {2'b00, position};
  assign level   = STEP_LEVEL[idx];
  assign dur     = STEP_DUR[idx];
  assign len_raw = PAT_LEN[pattern];
  assign len     = ({2'b00, len_raw} > MaxSteps) ? MaxSteps[2:0] : len_raw;

endmodule

>>> src/bps_core.sv
// Sequencer state and its combinational next-state logic for one request.
// Depends on bps_pkg and bps_rom.
`timescale 1ns / 1ps

module bps_core import bps_pkg::*; #(
  parameter int MAX_STEPS     = 4,
  parameter int PATTERN_COUNT = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  req_t req,
  output res_t res
);

  localparam logic [4:0] PatternCount = 5'(PATTERN_COUNT);

  logic        running, running_next;
  logic [2:0]  current_pattern, current_pattern_next;
  logic [2:0]  step_position, step_position_next;
  logic [63:0] deadline_ms, deadline_ms_next;
  logic        drive_level, drive_level_next;

  logic        is_play;
  logic [2:0]  sel_pat;
  logic [2:0]  sel_pos;
  logic        rom_level;
  logic [7:0]  rom_dur;
  logic [2:0]  rom_len;
  logic        do_drive;
  logic        do_halt;

  assign is_play = (req.req_type == REQ_PLAY);
  assign sel_pat = is_play ? req.pattern_id : current_pattern;
  assign sel_pos = is_play ? 3'd0 : step_position + 3'd1;

  bps_rom #(.MAX_STEPS(MAX_STEPS)) u_rom (
    .pattern (sel_pat),
    .position(sel_pos),
    .level   (rom_level),
    .dur     (rom_dur),
    .len     (rom_len)
  );

  always_comb begin
    running_next         = running;
    current_pattern_next = current_pattern;
    step_position_next   = step_position;
    deadline_ms_next     = deadline_ms;
    drive_level_next     = drive_level;
    do_drive             = 1'b0;
    do_halt              = 1'b0;

    unique case (req.req_type)
      REQ_PLAY: begin
        if ({2'b00, req.pattern_id} < PatternCount) begin
          if (rom_len == 3'd0) begin
            do_halt = 1'b1;
          end else begin
            running_next         = 1'b1;
            current_pattern_next = req.pattern_id;
            do_drive             = 1'b1;
          end
        end
      end
      REQ_STOP: begin
        do_halt = 1'b1;
      end
      REQ_TICK: begin
        if (running && (req.now_ms >= deadline_ms)) begin
          if (sel_pos >= rom_len) begin
            do_halt = 1'b1;
          end else begin
            do_drive = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_drive) begin
      drive_level_next   = rom_level;
      deadline_ms_next   = req.now_ms + {56'd0, rom_dur};
      step_position_next = sel_pos;
      if (rom_dur == 8'd0) begin
        if ((sel_pos + 3'd1) >= rom_len) begin
          do_halt = 1'b1;
        end else begin
          step_position_next = sel_pos + 3'd1;
        end
      end
    end

    if (do_halt) begin
      running_next         = 1'b0;
      current_pattern_next = 3'd0;
      step_position_next   = 3'd0;
      deadline_ms_next     = 64'd0;
      drive_level_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      current_pattern <= 3'd0;
      step_position   <= 3'd0;
      deadline_ms     <= 64'd0;
      drive_level     <= 1'b0;
    end else if (en) begin
      running         <= running_next;
      current_pattern <= current_pattern_next;
      step_position   <= step_position_next;
      deadline_ms     <= deadline_ms_next;
      drive_level     <= drive_level_next;
    end
  end

  assign res.buzzer_on = drive_level_next;
  assign res.playing   = running_next;

endmodule

>>> src/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer. Each request (play, stop or tick) yields exactly
// one result; the request is held in the request register and its result
// in the result register. One request is accepted per cycle while the
// output is not stalled; that rate is set by the combinational state
// update, which does a pattern ROM read, a 64-bit deadline compare and a
// 64-bit add. While a result waits to be read, one more request is taken
// into the request register; after that the input stalls.
`timescale 1ns / 1ps

module buzzer_pattern_sequencer import bps_pkg::*; #(
  parameter int MAX_STEPS     = 4,
  parameter int PATTERN_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  pattern_id,
  input  logic [63:0] now_ms,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        buzzer_on,
  output logic        playing
);

  req_t req_q;
  logic req_q_valid;
  res_t core_res;
  res_t res_q;
  logic advance;

  assign advance   = !res_valid || !res_stall;
  assign req_stall = req_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q.req_type   <= req_type;
      req_q.pattern_id <= pattern_id;
      req_q.now_ms     <= now_ms;
    end
  end

  bps_core #(
    .MAX_STEPS    (MAX_STEPS),
    .PATTERN_COUNT(PATTERN_COUNT)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .en (advance && req_q_valid),
    .req(req_q),
    .res(core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_q_valid) begin
      res_q <= core_res;
    end
  end

  assign buzzer_on = res_q.buzzer_on;
  assign playing   = res_q.playing;

endmodule

>>> src/bps_checker.sv
// Port-level checker for the buzzer pattern sequencer, bound to the top.
// Depends on buzzer_pattern_sequencer_macros.svh.
`timescale 1ns / 1ps
`include "buzzer_pattern_sequencer_macros.svh"

module bps_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic res_valid,
  input logic res_stall,
  input logic buzzer_on,
  input logic playing
);

  // an idle sequencer never leaves the buzzer sounding
  `BPS_ASSERT_IMPLY(a_idle_silent, res_valid && !playing, !buzzer_on)

  // an empty result register never holds back a request
  `BPS_ASSERT_IMPLY(a_no_stall_when_empty, !res_valid, !req_stall)

  `BPS_ASSERT_NEXT(a_result_held, res_valid && res_stall,
                   res_valid && $stable(buzzer_on) && $stable(playing))

  `BPS_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !res_valid && !req_stall)

endmodule

bind buzzer_pattern_sequencer bps_checker u_bps_checker (.*);

>>> sim/buzzer_pattern_checker.sv
// Checker for the buzzer pattern sequencer: predicts the buzzer level and
// playing flag for each accepted request and compares them with the results.
// Depends on bps_pkg for the request codes and the result struct.
`timescale 1ns / 1ps

module buzzer_pattern_checker import bps_pkg::*; #(
  parameter int MAX_STEPS     = 4,
  parameter int PATTERN_COUNT = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  pattern_id,
  input  logic [63:0] now_ms,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic        buzzer_on,
  input  logic        playing,
  output int          failures,
  output int          pending,
  output int          checked
);

  localparam bit TONE_LVL [22] = '{
    1'b1, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0
  };
  localparam int unsigned TONE_MS [22] = '{
    100, 0,
    120, 120, 120, 0,
    90, 60, 160, 0,
    180, 0,
    90, 90, 90, 0,
    220, 80, 220, 0,
    250, 0
  };
  localparam int unsigned PAT_FIRST [8] = '{0, 2, 6, 10, 12, 16, 20, 0};
  localparam int unsigned PAT_STEPS [8] = '{2, 4, 4, 2, 4, 4, 2, 0};

  bit          sounding;
  logic [2:0]  tune;
  int unsigned step;
  logic [63:0] due_ms;
  bit          level;
  res_t        expected_out [$];

  function automatic int unsigned steps_of(input logic [2:0] p);
    int unsigned n;
    n = PAT_STEPS[p];
    if (n > MAX_STEPS) n = MAX_STEPS;
    return n;
  endfunction

  function automatic void silence();
    sounding = 1'b0;
    tune     = '0;
    step     = 0;
    due_ms   = '0;
    level    = 1'b0;
  endfunction

  function automatic void sound_step(input logic [63:0] now);
    int unsigned idx;
    if (step >= steps_of(tune)) begin
      silence();
      return;
    end
    idx    = PAT_FIRST[tune] + step;
    level  = TONE_LVL[idx];
    due_ms = now + 64'(TONE_MS[idx]);
    if (TONE_MS[idx] == 0) begin
      step++;
      if (step >= steps_of(tune)) silence();
    end
  endfunction

  function automatic res_t predict_buzzer(input logic [1:0] kind, input logic [2:0] pid,
                                          input logic [63:0] now);
    res_t r;
    case (kind)
      REQ_PLAY: begin
        if (pid < PATTERN_COUNT) begin
          if (steps_of(pid) == 0) begin
            silence();
          end else begin
            tune     = pid;
            step     = 0;
            sounding = 1'b1;
            sound_step(now);
          end
        end
      end
      REQ_STOP: begin
        silence();
      end
      REQ_TICK: begin
        if (sounding && now >= due_ms) begin
          step++;
          if (step >= steps_of(tune)) silence();
          else sound_step(now);
        end
      end
      default: ;
    endcase
    r.buzzer_on = level;
    r.playing   = sounding;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      silence();
      expected_out.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_out.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result buzzer_on %0b playing %0b",
                     $time, buzzer_on, playing);
        end else begin
          want = expected_out.pop_front();
          checked++;
          if (want.buzzer_on !== buzzer_on || want.playing !== playing) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch buzzer_on exp %0b got %0b, playing exp %0b got %0b",
                       $time, want.buzzer_on, buzzer_on, want.playing, playing);
          end
        end
      end
      if (req_valid && !req_stall)
        expected_out.push_back(predict_buzzer(req_type, pattern_id, now_ms));
    end
    pending = expected_out.size();
  end

endmodule

>>> sim/tb_buzzer_pattern_sequencer.sv
// Testbench top for the buzzer pattern sequencer: drives directed and random
// requests with random idling and output hold-off, and reports the verdict.
// Depends on bps_pkg, buzzer_pattern_sequencer and buzzer_pattern_checker.
`timescale 1ns / 1ps

module tb_buzzer_pattern_sequencer;
  import bps_pkg::*;

  localparam int MAX_STEPS     = 4;
  localparam int PATTERN_COUNT = 7;
  localparam int TOTAL_REQS    = 975;
  localparam int HOLD_CYCLES   = 80;

  localparam logic [1:0] REQ_BAD = 2'd3;

  localparam logic [2:0] PAT_TICK      = 3'd0;
  localparam logic [2:0] PAT_REJECTED  = 3'd1;
  localparam logic [2:0] PAT_MOWING    = 3'd2;
  localparam logic [2:0] PAT_DOCKING   = 3'd3;
  localparam logic [2:0] PAT_CHARGER   = 3'd4;
  localparam logic [2:0] PAT_SHUTDOWN  = 3'd5;
  localparam logic [2:0] PAT_EMERGENCY = 3'd6;
  localparam logic [2:0] PAT_NONE      = 3'd7;

  localparam int unsigned STEP_GAPS [9] = '{60, 80, 90, 100, 120, 160, 180, 220, 250};

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  req_type;
  logic [2:0]  pattern_id;
  logic [63:0] now_ms;
  logic        res_valid;
  logic        res_stall;
  logic        buzzer_on;
  logic        playing;

  int failures;
  int pending;
  int checked;

  bit          send_idle;
  bit          recv_idle;
  bit          hold_off;
  logic [63:0] clock_ms;
  int          n_sent;
  int          n_play;
  int          n_stop;
  int          n_tick;
  int          n_other;
  int          n_backpressure;

  buzzer_pattern_sequencer #(
    .MAX_STEPS    (MAX_STEPS),
    .PATTERN_COUNT(PATTERN_COUNT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .pattern_id(pattern_id),
    .now_ms    (now_ms),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .buzzer_on (buzzer_on),
    .playing   (playing)
  );

  buzzer_pattern_checker #(
    .MAX_STEPS    (MAX_STEPS),
    .PATTERN_COUNT(PATTERN_COUNT)
  ) chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .pattern_id(pattern_id),
    .now_ms    (now_ms),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .buzzer_on (buzzer_on),
    .playing   (playing),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // output side: random stall bursts, plus one long hold-off on request
  initial begin
    res_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off = 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [2:0] pid, input logic [63:0] now);
    int gap;
    @(negedge clk);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    pattern_id <= pid;
    now_ms     <= now;
    @(posedge clk);
    while (req_stall) begin
      n_backpressure++;
      @(posedge clk);
    end
    n_sent++;
    case (kind)
      REQ_PLAY: n_play++;
      REQ_STOP: n_stop++;
      REQ_TICK: n_tick++;
      default:  n_other++;
    endcase
  endtask

  // one play request followed by ticks, with a little noise mixed in
  task automatic run_tune();
    int          pick;
    logic [63:0] step_ms;
    pick = $urandom_range(0, 15);
    if (pick == 0) clock_ms = {$urandom, $urandom};
    else if (pick == 1) clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 400));
    if ($urandom_range(0, 15) == 0) send_req(REQ_PLAY, PAT_NONE, clock_ms);
    else send_req(REQ_PLAY, 3'($urandom_range(0, 6)), clock_ms);
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
        send_req(REQ_STOP, 3'($urandom), {$urandom, $urandom});
      end else if (pick == 1) begin
        send_req(REQ_BAD, 3'($urandom), {$urandom, $urandom});
      end else if (pick == 2) begin
        send_req(2'($urandom), 3'($urandom), {$urandom, $urandom});
      end else begin
        if ($urandom_range(0, 1) == 1)
          step_ms = 64'(STEP_GAPS[$urandom_range(0, 8)]) + 64'($urandom_range(0, 2)) - 64'd1;
        else
          step_ms = 64'($urandom_range(0, 300));
        clock_ms = clock_ms + step_ms;
        send_req(REQ_TICK, 3'($urandom), clock_ms);
      end
    end
  endtask

  initial begin
    bit pressure_done;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = REQ_TICK;
    pattern_id = PAT_TICK;
    now_ms     = '0;
    send_idle  = 1'b1;
    recv_idle  = 1'b1;
    hold_off   = 1'b0;
    clock_ms   = 64'd5000;
    pressure_done = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_req(REQ_TICK, PAT_TICK, 64'd0);
    send_req(REQ_PLAY, PAT_TICK, 64'd0);
    send_req(REQ_TICK, PAT_TICK, 64'd99);
    send_req(REQ_TICK, PAT_TICK, 64'd100);
    send_req(REQ_PLAY, PAT_NONE, 64'd5);
    send_req(REQ_BAD, PAT_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(REQ_PLAY, PAT_EMERGENCY, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(REQ_TICK, PAT_TICK, 64'd248);
    send_req(REQ_TICK, PAT_TICK, 64'd249);
    send_req(REQ_PLAY, PAT_REJECTED, 64'd1000);
    send_req(REQ_TICK, PAT_TICK, 64'd1120);
    send_req(REQ_TICK, PAT_TICK, 64'd1240);
    send_req(REQ_STOP, PAT_NONE, 64'd1250);
    send_req(REQ_TICK, PAT_TICK, 64'd2000);
    send_req(REQ_PLAY, PAT_MOWING, 64'd3000);
    send_req(REQ_PLAY, PAT_DOCKING, 64'd3010);
    send_req(REQ_TICK, PAT_TICK, 64'd3190);
    send_req(REQ_PLAY, PAT_CHARGER, 64'h8000_0000_0000_0000);
    send_req(REQ_TICK, PAT_TICK, 64'h8000_0000_0000_005A);
    send_req(REQ_TICK, PAT_TICK, 64'h8000_0000_0000_00B4);
    send_req(REQ_TICK, PAT_TICK, 64'h8000_0000_0000_010E);
    send_req(REQ_PLAY, PAT_SHUTDOWN, 64'd0);
    send_req(REQ_TICK, PAT_TICK, 64'd220);
    send_req(REQ_TICK, PAT_TICK, 64'd300);
    send_req(REQ_TICK, PAT_TICK, 64'd520);

    while (n_sent < TOTAL_REQS) begin
      if (!pressure_done && n_sent >= 300) begin
        pressure_done = 1'b1;
        send_idle = 1'b0;
        hold_off  = 1'b1;
      end else if (pressure_done && n_sent >= 380 && n_sent < TOTAL_REQS - 150) begin
        send_idle = 1'b1;
      end
      if (n_sent >= TOTAL_REQS - 150) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      run_tune();
    end

    @(negedge clk);
    req_valid <= 1'b0;
    wait (pending == 0);
    repeat (6) @(posedge clk);

    $display("Run covered %0d requests (%0d play, %0d stop, %0d tick, %0d other type)",
             n_sent, n_play, n_stop, n_tick, n_other);
    $display("%0d results checked, %0d cycles of input backpressure seen",
             checked, n_backpressure);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
